@@ rtl/mbrx_pkg.sv @@
// Shared constants and types for the Modbus RTU response receiver.
package mbrx_pkg;

  localparam int BUFFER_BYTES  = 64;
  localparam int MAX_REGISTERS = 16;

  localparam int ADDR_W  = $clog2(BUFFER_BYTES);
  localparam int COUNT_W = $clog2(BUFFER_BYTES + 1);
  localparam int REGS_W  = $clog2(MAX_REGISTERS + 1);
  localparam int CMP_W   = 9;

  localparam logic [7:0]  ADDRESS_BYTE = 8'hFE;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam int          FRAME_EXTRA  = 5;
  localparam int          FIRST_DATA   = 3;
  localparam logic [4:0]  REG_COUNT_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_REG    = 1'b1;
  localparam logic MODE_BYTE   = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CRC     = 7'b0000010,
    S_CHECK   = 7'b0000100,
    S_STATUS  = 7'b0001000,
    S_RD_HI   = 7'b0010000,
    S_RD_LO   = 7'b0100000,
    S_REG_OUT = 7'b1000000
  } state_t;

endpackage

@@ rtl/modbus_rtu_response_receiver.sv @@
// Modbus RTU response receiver: frame buffer, bit-serial CRC-16 and result emission.
// A byte is taken in S_IDLE, then the CRC runs one bit per cycle in S_CRC and S_CHECK judges the
// frame, so no new byte is taken until the judgement is done. A tick on an empty frame is taken
// and changes nothing; a timeout tick passes through S_STATUS, which waits for a free output.
// A finished frame gives its status from S_STATUS once the output is free; each register word
// then passes through S_RD_HI, S_RD_LO and S_REG_OUT, as the frame store has a single read port.
// Reset is synchronous and active high: it empties the frame, sets the CRC to all ones and
// register_count to 16. The frame store is not cleared; only bytes of the current frame are read.
module modbus_rtu_response_receiver
  import mbrx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [3:0] reg_index, [19:4] reg_value, [21:20] status, zero fill
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data   // [4:0] register_count
);

  state_t             state;
  logic [4:0]         register_count;
  logic [15:0]        crc;
  logic [COUNT_W-1:0] byte_count;
  logic               first_is_address;
  logic [2:0]         bit_cnt;
  logic [REGS_W-1:0]  regs_eff;
  logic [REGS_W-1:0]  reg_idx;
  logic [ADDR_W-1:0]  rd_ptr;
  logic [7:0]         rd_data;
  logic [7:0]         hi_byte;
  status_t            status_code;
  logic               status_last;
  logic [7:0]         frame_store [BUFFER_BYTES];

  logic               in_xfer;
  logic               out_free;
  logic               out_load;
  logic               skip_byte;
  logic [CMP_W-1:0]   cfg_ext;
  logic [CMP_W-1:0]   regs_sel;
  logic [CMP_W-1:0]   need;
  logic               complete;
  logic               last_reg;

  assign s_tready  = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign in_xfer   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign skip_byte = (byte_count == '0) && (s_tdata == 8'h00);

  assign cfg_ext  = CMP_W'(register_count);
  assign regs_sel = (cfg_ext > CMP_W'(MAX_REGISTERS)) ? CMP_W'(MAX_REGISTERS) : cfg_ext;
  assign need     = CMP_W'(2 * regs_sel + CMP_W'(FRAME_EXTRA));
  assign complete = first_is_address && (CMP_W'(byte_count) >= need);
  assign last_reg = (reg_idx + REGS_W'(1)) == regs_eff;

  assign out_load = ((state == S_STATUS) || (state == S_REG_OUT)) && out_free;

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (in_xfer && (s_tuser == MODE_BYTE) && !skip_byte) begin
      frame_store[byte_count[ADDR_W-1:0]] <= s_tdata;
    end
    if ((state == S_RD_HI) || (state == S_RD_LO)) begin
      rd_data <= frame_store[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      register_count <= REG_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      register_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      crc              <= CRC_INIT;
      byte_count       <= '0;
      first_is_address <= 1'b0;
      bit_cnt          <= '0;
      regs_eff         <= '0;
      reg_idx          <= '0;
      rd_ptr           <= '0;
      status_code      <= ST_OK;
      status_last      <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (s_tuser == MODE_TICK) begin
              if (byte_count != '0) begin
                status_code      <= ST_TIMEOUT;
                status_last      <= 1'b1;
                regs_eff         <= '0;
                crc              <= CRC_INIT;
                byte_count       <= '0;
                first_is_address <= 1'b0;
                state            <= S_STATUS;
              end
            end else if (!skip_byte) begin
              if (byte_count == '0) begin
                first_is_address <= (s_tdata == ADDRESS_BYTE);
              end
              byte_count <= byte_count + COUNT_W'(1);
              crc        <= crc ^ {8'h00, s_tdata};
              bit_cnt    <= '0;
              state      <= S_CRC;
            end
          end
        end
        S_CRC: begin
          crc     <= crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          reg_idx <= '0;
          rd_ptr  <= ADDR_W'(FIRST_DATA);
          if (complete) begin
            if (crc != 16'h0000) begin
              status_code <= ST_CRC_ERR;
              status_last <= 1'b1;
              regs_eff    <= '0;
            end else begin
              status_code <= ST_OK;
              status_last <= (regs_sel == '0);
              regs_eff    <= REGS_W'(regs_sel);
            end
            crc              <= CRC_INIT;
            byte_count       <= '0;
            first_is_address <= 1'b0;
            state            <= S_STATUS;
          end else if (CMP_W'(byte_count) >= CMP_W'(BUFFER_BYTES)) begin
            status_code      <= ST_OVERFLOW;
            status_last      <= 1'b1;
            regs_eff         <= '0;
            crc              <= CRC_INIT;
            byte_count       <= '0;
            first_is_address <= 1'b0;
            state            <= S_STATUS;
          end else begin
            state <= S_IDLE;
          end
        end
        S_STATUS: begin
          if (out_free) begin
            state <= status_last ? S_IDLE : S_RD_HI;
          end
        end
        S_RD_HI: begin
          rd_ptr <= rd_ptr + ADDR_W'(1);
          state  <= S_RD_LO;
        end
        S_RD_LO: begin
          hi_byte <= rd_data;
          rd_ptr  <= rd_ptr + ADDR_W'(1);
          state   <= S_REG_OUT;
        end
        S_REG_OUT: begin
          if (out_free) begin
            reg_idx <= reg_idx + REGS_W'(1);
            state   <= last_reg ? S_IDLE : S_RD_HI;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: holds one result until the downstream transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_STATUS) begin
        m_tuser <= KIND_STATUS;
        m_tdata <= {2'b00, status_code, 16'h0000, 4'h0};
        m_tlast <= status_last;
      end else begin
        m_tuser <= KIND_REG;
        m_tdata <= {2'b00, ST_OK, hi_byte, rd_data, reg_idx[3:0]};
        m_tlast <= last_reg;
      end
    end
  end

  // The frame never holds more bytes than the buffer.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(byte_count) <= CMP_W'(BUFFER_BYTES))
    else $error("byte count beyond buffer size");

  // A result is only loaded when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");

  // Register items always carry an ok status.
  a_reg_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_REG)) |-> (m_tdata[21:20] == ST_OK))
    else $error("register item with non-ok status");

  // A tick on a partial frame leads straight to a timeout status.
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (s_tuser == MODE_TICK) && (byte_count != '0))
      |=> ((state == S_STATUS) && (status_code == ST_TIMEOUT) && (byte_count == '0)))
    else $error("timeout not reported");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the Modbus RTU response receiver, with a frame-level scoreboard.
module tb_top;
  import mbrx_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 36;
  localparam int REPORT_MAX    = 10;
  localparam logic [7:0] READ_HOLDING = 8'h03;

  typedef struct packed {
    logic        kind;
    logic [3:0]  idx;
    logic [15:0] value;
    status_t     st;
    logic        last;
  } rx_result_t;

  // Tracks the frame being assembled and queues the results each byte or tick should give.
  class modbus_frame_model;
    logic [15:0] crc;
    int unsigned fill;
    logic [7:0]  frame_bytes [BUFFER_BYTES];
    bit          addr_first;
    logic [4:0]  count_cfg;
    rx_result_t  due_results [$];
    int unsigned errors;
    int unsigned counted;

    function new();
      count_cfg = REG_COUNT_RESET;
      errors = 0;
      counted = 0;
      clear();
    endfunction

    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
        r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
    endfunction

    function void clear();
      crc = CRC_INIT;
      fill = 0;
      addr_first = 1'b0;
    endfunction

    function void add(logic kind, logic [3:0] idx, logic [15:0] value, status_t st,
                      logic last);
      rx_result_t r;
      r.kind = kind;
      r.idx = idx;
      r.value = value;
      r.st = st;
      r.last = last;
      due_results.push_back(r);
    endfunction

    function void receive_item(logic mode, logic [7:0] b);
      int unsigned regs;
      int unsigned need;
      if (mode == MODE_TICK) begin
        if (fill == 0)
          return;
        counted++;
        add(KIND_STATUS, 4'd0, 16'd0, ST_TIMEOUT, 1'b1);
        clear();
        return;
      end
      // Zero bytes ahead of the first byte of a frame are line noise.
      if (fill == 0 && b == 8'h00)
        return;
      counted++;
      if (fill < BUFFER_BYTES) begin
        frame_bytes[fill] = b;
        if (fill == 0)
          addr_first = (b == ADDRESS_BYTE);
        fill++;
      end
      crc = crc_step(crc, b);
      regs = (count_cfg > MAX_REGISTERS) ? MAX_REGISTERS : count_cfg;
      need = 2 * regs + FRAME_EXTRA;
      if (addr_first && fill >= need) begin
        if (crc != 16'h0000) begin
          add(KIND_STATUS, 4'd0, 16'd0, ST_CRC_ERR, 1'b1);
        end else begin
          add(KIND_STATUS, 4'd0, 16'd0, ST_OK, regs == 0);
          for (int i = 0; i < regs; i++)
            add(KIND_REG, 4'(i),
                {frame_bytes[FIRST_DATA + 2 * i], frame_bytes[FIRST_DATA + 2 * i + 1]},
                ST_OK, i + 1 == regs);
        end
        clear();
      end else if (fill >= BUFFER_BYTES) begin
        add(KIND_STATUS, 4'd0, 16'd0, ST_OVERFLOW, 1'b1);
        clear();
      end
    endfunction

    function void compare_result(rx_result_t got);
      rx_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result: kind=%0d idx=%0d value=%h status=%0d last=%0d",
                   got.kind, got.idx, got.value, got.st, got.last);
        return;
      end
      want = due_results.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("result mismatch: expected kind=%0d idx=%0d value=%h status=%0d last=%0d, %s",
                   want.kind, want.idx, want.value, want.st, want.last,
                   $sformatf("got kind=%0d idx=%0d value=%h status=%0d last=%0d",
                             got.kind, got.idx, got.value, got.st, got.last));
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;    // [7:0] byte_value
  logic        s_tuser = 1'b0;     // [0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;            // [3:0] reg_index, [19:4] reg_value, [21:20] status
  logic        m_tuser;            // [0] kind
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = 5'd0;    // [4:0] register_count

  modbus_frame_model model;
  logic [4:0] cur_count = REG_COUNT_RESET;
  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;
  logic       hold_req = 1'b0;
  logic       hold_taken = 1'b0;
  int         hold_cnt = 0;
  int         cycles = 0;

  modbus_rtu_response_receiver dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off so that the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    rx_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tuser;
      got.idx = m_tdata[3:0];
      got.value = m_tdata[19:4];
      got.st = status_t'(m_tdata[21:20]);
      got.last = m_tlast;
      model.compare_result(got);
    end
  end

  function automatic int eff_regs();
    return (cur_count > MAX_REGISTERS) ? MAX_REGISTERS : int'(cur_count);
  endfunction

  task automatic send_item(input logic mode, input logic [7:0] value);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= value;
    do @(posedge clk); while (!s_tready);
    model.receive_item(mode, value);
  endtask

  // Builds a response frame for the current register count; optionally corrupts one bit,
  // fills the data with ones or drops bytes from the tail.
  task automatic send_frame(input bit damage, input int cut, input bit ones);
    logic [7:0]  fr [$];
    logic [15:0] c;
    int          n;
    int          k;
    n = eff_regs();
    fr.push_back(ADDRESS_BYTE);
    fr.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : READ_HOLDING);
    fr.push_back(8'(2 * n));
    for (k = 0; k < 2 * n; k++)
      fr.push_back(ones ? 8'hFF : 8'($urandom));
    c = CRC_INIT;
    for (k = 0; k < fr.size(); k++)
      c = modbus_frame_model::crc_step(c, fr[k]);
    fr.push_back(c[7:0]);
    fr.push_back(c[15:8]);
    if (damage) begin
      k = $urandom_range(1, fr.size() - 1);
      fr[k] = fr[k] ^ 8'(1 << $urandom_range(0, 7));
    end
    for (k = 0; k < fr.size() - cut; k++)
      send_item(MODE_BYTE, fr[k]);
  endtask

  task automatic send_foreign_start();
    logic [7:0] b;
    b = 8'($urandom_range(1, 254));
    if (b == ADDRESS_BYTE)
      b = 8'hFF;
    send_item(MODE_BYTE, b);
  endtask

  // One sequence; every kind leaves the receiver with an empty frame.
  task automatic run_sequence(input int sel);
    if (sel < 55) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) send_item(MODE_BYTE, 8'h00);
      send_frame(1'b0, 0, 1'b0);
    end else if (sel < 70) begin
      send_frame(1'b1, 0, 1'b0);
    end else if (sel < 80) begin
      send_frame(1'b0, $urandom_range(1, 2 * eff_regs() + 4), 1'b0);
      send_item(MODE_TICK, 8'($urandom));
    end else if (sel < 88) begin
      send_foreign_start();
      repeat ($urandom_range(0, 8)) send_item(MODE_BYTE, 8'($urandom));
      send_item(MODE_TICK, 8'($urandom));
    end else if (sel < 95) begin
      repeat ($urandom_range(1, 6)) send_item(1'($urandom_range(0, 1)), 8'($urandom));
      send_item(MODE_TICK, 8'($urandom));
    end else if (sel < 98) begin
      send_item(MODE_TICK, 8'($urandom));
      send_item(MODE_BYTE, 8'h00);
    end else begin
      // A frame that never claims the address fills the whole buffer.
      send_foreign_start();
      repeat (BUFFER_BYTES - 1) send_item(MODE_BYTE, 8'($urandom));
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [4:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model.count_cfg = value;
    cur_count = value;
  endtask

  initial begin
    logic [4:0] phase_counts [6];
    int         target;
    model = new();
    phase_counts[0] = 5'd1;
    phase_counts[1] = 5'd31;
    phase_counts[2] = 5'd0;
    phase_counts[3] = 5'd16;
    phase_counts[4] = 5'd17;
    phase_counts[5] = 5'($urandom_range(2, 15));
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty-frame tick and a skipped zero, then a partial frame ended by a tick.
    send_item(MODE_TICK, 8'h00);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_TICK, 8'hA5);
    write_count(5'd0);
    send_frame(1'b0, 0, 1'b0);
    send_frame(1'b1, 0, 1'b0);
    write_count(5'd1);
    send_frame(1'b0, 0, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      write_count(phase_counts[ph]);
      tx_idle_pct = (ph % 4 == 1) ? 76 : (ph % 4 == 3) ? 11 : 0;
      rx_stall_pct = (ph % 4 == 2) ? 76 : (ph % 4 == 3) ? 11 : 0;
      if (ph == 4)
        hold_req <= 1'b1;
      if (ph == 1)
        run_sequence(99);
      target = model.counted + PHASE_ITEMS;
      while (model.counted < target)
        run_sequence($urandom_range(0, 99));
    end

    wait_drained();
    if (model.errors == 0 && model.pending() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
